[sv/mrs_pkg.sv]
// Package for the mark range exclusion search block.
// Holds codes, field widths and the divider request and response types.
// Depends on nothing.
`default_nettype none
package mrs_pkg;

    localparam int unsigned MARK_W = 32;

    localparam logic [1:0] MODE_NEW   = 2'd0;
    localparam logic [1:0] MODE_ANS   = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    localparam logic [1:0] KIND_REQ    = 2'd0;
    localparam logic [1:0] KIND_MERGED = 2'd1;
    localparam logic [1:0] KIND_EXACT  = 2'd2;

    localparam logic [1:0] REG_SPLIT = 2'd0;
    localparam logic [1:0] REG_GAP   = 2'd1;
    localparam logic [1:0] REG_EXACT = 2'd2;

    typedef struct packed {
        logic              start;
        logic [MARK_W-1:0] dividend;
        logic [MARK_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [MARK_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

[sv/mrs_in_if.sv]
// Interfaces for the input and result channels of the search block.
// Depends on mrs_pkg.
`default_nettype none
interface mrs_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic [mrs_pkg::MARK_W-1:0] range_begin;
    logic [mrs_pkg::MARK_W-1:0] range_end;
    logic                      may_match;
    logic                      may_miss;

    modport source (output valid, mode, range_begin, range_end, may_match, may_miss,
                    input ready);
    modport sink (input valid, mode, range_begin, range_end, may_match, may_miss,
                  output ready);
endinterface

interface mrs_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [mrs_pkg::MARK_W-1:0] out_begin;
    logic [mrs_pkg::MARK_W-1:0] out_end;
    logic [31:0]               step_count;
    logic                      overflowed;
    logic                      last;

    modport source (output valid, kind, out_begin, out_end, step_count, overflowed, last,
                    input ready);
    modport sink (input valid, kind, out_begin, out_end, step_count, overflowed, last,
                  output ready);
endinterface
`default_nettype wire

[sv/mark_range_exclusion_search_top.sv]
// Each word runs through a sequencer; a new word is taken only once every result of the last
// one has been delivered. An answer that splits a range runs two divisions for the subrange
// width and count; unless the subranges would not fit the stack, it then writes one subrange
// per cycle into the stack memory. Every answer then pops the top entry, if any, through the
// registered memory read.
// Depends on mrs_pkg, mrs_in_if, mrs_out_if, mrs_div and mrs_stack_mem.
`default_nettype none
module mark_range_exclusion_search_top #(
    parameter int unsigned STACK_DEPTH = 256,
    parameter int unsigned MARK_BITS   = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mrs_in_if.sink           in_ch,
    mrs_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int unsigned W  = mrs_pkg::MARK_W;
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = AW + 1;
    localparam logic [W-1:0] MARK_MASK = W'((64'd1 << MARK_BITS) - 64'd1);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV1, S_DIV2, S_PUSH, S_POP, S_POPWAIT, S_EMIT
    } state_t;

    state_t          state_reg;
    logic [6:0]      split_reg;
    logic [15:0]     gap_reg;
    logic            exact_en_reg;
    logic [CW-1:0]   cnt_reg;
    logic [63:0]     checked_reg;
    logic            await_reg;
    logic            om_v_reg;
    logic [W-1:0]    om_b_reg;
    logic [W-1:0]    om_e_reg;
    logic            ox_v_reg;
    logic [W-1:0]    ox_b_reg;
    logic [W-1:0]    ox_e_reg;
    logic [31:0]     steps_reg;
    logic            refused_reg;
    logic            em_m_reg;
    logic            em_x_reg;
    logic            em_q_reg;
    logic [W-1:0]    em_m_b_reg;
    logic [W-1:0]    em_m_e_reg;
    logic [W-1:0]    em_x_b_reg;
    logic [W-1:0]    em_x_e_reg;
    logic [W-1:0]    step_reg;
    logic [W-1:0]    cut_reg;
    logic            div_start_reg;
    logic [W-1:0]    div_dvd_reg;
    logic [W-1:0]    div_dvs_reg;

    mrs_pkg::div_req_t div_req;
    mrs_pkg::div_rsp_t div_rsp;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_data;

    logic [W-1:0] cb;
    logic [W-1:0] ce;
    logic [W-1:0] clen;
    logic [6:0]   g;
    logic         m_can;
    logic         x_can;
    logic [W:0]   b_plus_step;
    logic         push_more;
    logic [W-1:0] nb;
    logic [W-1:0] ne;
    logic         in_acc;
    logic         out_acc;
    logic [32:0]  parts_sum;
    logic         split_now;

    assign cb   = checked_reg[63:32];
    assign ce   = checked_reg[31:0];
    assign clen = (ce > cb) ? ce - cb : '0;
    assign g    = (split_reg < 7'd2) ? 7'd2 : ((split_reg > 7'd64) ? 7'd64 : split_reg);

    assign m_can = om_v_reg && (cb >= om_e_reg) && ((cb - om_e_reg) <= {16'd0, gap_reg});
    assign x_can = ox_v_reg && (cb == ox_e_reg);

    assign split_now = in_ch.may_match && (clen != '0) && in_ch.may_miss && (clen != W'(1));

    assign b_plus_step = {1'b0, cb} + {1'b0, step_reg};
    assign push_more   = {1'b0, cut_reg} > b_plus_step;
    assign parts_sum   = 33'(cnt_reg) + 33'(div_rsp.quotient) + 33'd1;

    assign nb = in_ch.range_begin & MARK_MASK;
    assign ne = in_ch.range_end & MARK_MASK;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_acc     = out_ch.valid && out_ch.ready;

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_dvd_reg;
    assign div_req.divisor  = div_dvs_reg;

    assign wr_en   = (state_reg == S_PUSH);
    assign wr_addr = cnt_reg[AW-1:0];
    assign wr_data = push_more ? {cut_reg - step_reg, cut_reg} : {cb, cut_reg};
    assign rd_en   = (state_reg == S_POP) && (cnt_reg != '0);
    assign rd_addr = AW'(cnt_reg - 1'b1);

    mrs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mrs_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_ch.valid = (state_reg == S_EMIT) && (em_m_reg || em_x_reg || em_q_reg);
        if (em_m_reg)
        begin
            out_ch.kind      = mrs_pkg::KIND_MERGED;
            out_ch.out_begin = em_m_b_reg;
            out_ch.out_end   = em_m_e_reg;
        end
        else if (em_x_reg)
        begin
            out_ch.kind      = mrs_pkg::KIND_EXACT;
            out_ch.out_begin = em_x_b_reg;
            out_ch.out_end   = em_x_e_reg;
        end
        else
        begin
            out_ch.kind      = mrs_pkg::KIND_REQ;
            out_ch.out_begin = cb;
            out_ch.out_end   = ce;
        end
        out_ch.step_count = steps_reg;
        out_ch.overflowed = refused_reg;
        out_ch.last       = ({1'b0, em_m_reg} + {1'b0, em_x_reg} + {1'b0, em_q_reg}) == 2'd1;
    end

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            mrs_pkg::REG_SPLIT: prdata = {25'd0, split_reg};
            mrs_pkg::REG_GAP:   prdata = {16'd0, gap_reg};
            mrs_pkg::REG_EXACT: prdata = {31'd0, exact_en_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_reg     <= 7'd8;
            gap_reg       <= '0;
            exact_en_reg  <= 1'b0;
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            checked_reg   <= '0;
            await_reg     <= 1'b0;
            om_v_reg      <= 1'b0;
            om_b_reg      <= '0;
            om_e_reg      <= '0;
            ox_v_reg      <= 1'b0;
            ox_b_reg      <= '0;
            ox_e_reg      <= '0;
            steps_reg     <= '0;
            refused_reg   <= 1'b0;
            em_m_reg      <= 1'b0;
            em_x_reg      <= 1'b0;
            em_q_reg      <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    mrs_pkg::REG_SPLIT: split_reg    <= pwdata[6:0];
                    mrs_pkg::REG_GAP:   gap_reg      <= pwdata[15:0];
                    mrs_pkg::REG_EXACT: exact_en_reg <= pwdata[0];
                    default:            ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (in_ch.mode)
                            mrs_pkg::MODE_NEW:
                            begin
                                if (!await_reg && (ne > nb))
                                begin
                                    cnt_reg     <= '0;
                                    checked_reg <= {nb, ne};
                                    await_reg   <= 1'b1;
                                    if (steps_reg != '1)
                                    begin
                                        steps_reg <= steps_reg + 1'b1;
                                    end
                                    em_q_reg  <= 1'b1;
                                    state_reg <= S_EMIT;
                                end
                            end
                            mrs_pkg::MODE_ANS:
                            begin
                                if (await_reg)
                                begin
                                    await_reg <= 1'b0;
                                    state_reg <= split_now ? S_DIV1 : S_POP;
                                    if (in_ch.may_match && (clen != '0))
                                    begin
                                        if (!in_ch.may_miss || (clen == W'(1)))
                                        begin
                                            if (m_can)
                                            begin
                                                om_e_reg <= ce;
                                            end
                                            else
                                            begin
                                                em_m_reg   <= om_v_reg;
                                                em_m_b_reg <= om_b_reg;
                                                em_m_e_reg <= om_e_reg;
                                                om_v_reg   <= 1'b1;
                                                om_b_reg   <= cb;
                                                om_e_reg   <= ce;
                                            end
                                            if (exact_en_reg && !in_ch.may_miss)
                                            begin
                                                if (x_can)
                                                begin
                                                    ox_e_reg <= ce;
                                                end
                                                else
                                                begin
                                                    em_x_reg   <= ox_v_reg;
                                                    em_x_b_reg <= ox_b_reg;
                                                    em_x_e_reg <= ox_e_reg;
                                                    ox_v_reg   <= 1'b1;
                                                    ox_b_reg   <= cb;
                                                    ox_e_reg   <= ce;
                                                end
                                            end
                                        end
                                        else
                                        begin
                                            div_start_reg <= 1'b1;
                                            div_dvd_reg   <= clen - 1'b1;
                                            div_dvs_reg   <= {25'd0, g};
                                        end
                                    end
                                end
                            end
                            mrs_pkg::MODE_FLUSH:
                            begin
                                em_m_reg   <= om_v_reg;
                                em_m_b_reg <= om_b_reg;
                                em_m_e_reg <= om_e_reg;
                                em_x_reg   <= ox_v_reg;
                                em_x_b_reg <= ox_b_reg;
                                em_x_e_reg <= ox_e_reg;
                                om_v_reg   <= 1'b0;
                                om_b_reg   <= '0;
                                om_e_reg   <= '0;
                                ox_v_reg   <= 1'b0;
                                ox_b_reg   <= '0;
                                ox_e_reg   <= '0;
                                state_reg  <= S_EMIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV1:
                begin
                    if (div_rsp.done)
                    begin
                        step_reg      <= div_rsp.quotient + 1'b1;
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= clen - 1'b1;
                        div_dvs_reg   <= div_rsp.quotient + 1'b1;
                        state_reg     <= S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    if (div_rsp.done)
                    begin
                        if (parts_sum > 33'(STACK_DEPTH))
                        begin
                            refused_reg <= 1'b1;
                            if (m_can)
                            begin
                                om_e_reg <= ce;
                            end
                            else
                            begin
                                em_m_reg   <= om_v_reg;
                                em_m_b_reg <= om_b_reg;
                                em_m_e_reg <= om_e_reg;
                                om_v_reg   <= 1'b1;
                                om_b_reg   <= cb;
                                om_e_reg   <= ce;
                            end
                            state_reg <= S_POP;
                        end
                        else
                        begin
                            cut_reg   <= ce;
                            state_reg <= S_PUSH;
                        end
                    end
                end
                S_PUSH:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (push_more)
                    begin
                        cut_reg <= cut_reg - step_reg;
                    end
                    else
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_POP:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= S_POPWAIT;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_POPWAIT:
                begin
                    checked_reg <= rd_data;
                    await_reg   <= 1'b1;
                    if (steps_reg != '1)
                    begin
                        steps_reg <= steps_reg + 1'b1;
                    end
                    em_q_reg  <= 1'b1;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!(em_m_reg || em_x_reg || em_q_reg))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_acc)
                    begin
                        if (em_m_reg)
                        begin
                            em_m_reg <= 1'b0;
                        end
                        else if (em_x_reg)
                        begin
                            em_x_reg <= 1'b0;
                        end
                        else
                        begin
                            em_q_reg <= 1'b0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/mrs_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on mrs_pkg.
`default_nettype none
module mrs_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mrs_pkg::div_req_t req,
    output mrs_pkg::div_rsp_t      rsp
);
    localparam int unsigned W = mrs_pkg::MARK_W;

    logic [W:0]             rem_reg;
    logic [W-1:0]           dvd_reg;
    logic [W-1:0]           dvs_reg;
    logic [W-1:0]           quo_reg;
    logic [$clog2(W+1)-1:0] cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [W:0]             rem_sh;

    assign rem_sh = {rem_reg[W-1:0], dvd_reg[W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                quo_reg  <= '0;
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[W-2:0], 1'b0};
                if (rem_sh >= {1'b0, dvs_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, dvs_reg};
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(W+1))'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

[sv/mrs_stack_mem.sv]
// Pending range stack storage: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none
module mrs_stack_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [63:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [63:0]        rd_data
);
    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

[sv/mrs_checker.sv]
// Port-level checks for the search block, and the bind that attaches them.
// Depends on mrs_pkg and mark_range_exclusion_search_top.
`default_nettype none
module mrs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  out_kind,
    input wire logic [31:0] out_begin,
    input wire logic [31:0] out_end
);
    a_no_take_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result word waits");

    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind == mrs_pkg::KIND_REQ || out_kind == mrs_pkg::KIND_MERGED ||
                       out_kind == mrs_pkg::KIND_EXACT))
        else $error("result word with unknown kind");

    a_req_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == mrs_pkg::KIND_REQ) |-> (out_end > out_begin))
        else $error("check request for an empty range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_begin)
                                       && $stable(out_end)))
        else $error("stalled result word changed");
endmodule

bind mark_range_exclusion_search_top mrs_checker u_mrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_begin (out_ch.out_begin),
    .out_end   (out_ch.out_end)
);
`default_nettype wire
